[hdl/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tprc_pkg.sv]
package tprc_pkg;

  localparam int LenW     = 32;
  localparam int RateW    = 31;
  localparam int ModeW    = 2;
  localparam int SumW     = LenW + 1;
  localparam int ProdW    = 2 * LenW;
  localparam int DivSteps = LenW;
  localparam int CntW     = $clog2(DivSteps);

  localparam logic [RateW-1:0] RateReset = RateW'(985248);

  localparam logic [ModeW-1:0] ModeUnchanged  = 2'd0;
  localparam logic [ModeW-1:0] ModeHalfToFull = 2'd1;
  localparam logic [ModeW-1:0] ModeFullToHalf = 2'd2;

  localparam logic [1:0] RegInRate   = 2'd0;
  localparam logic [1:0] RegOutRate  = 2'd1;
  localparam logic [1:0] RegWaveMode = 2'd2;

  typedef struct packed {
    logic accept;
    logic mul;
    logic check;
    logic div_step;
    logic emit_first;
    logic emit_second;
  } cmd_t;

  typedef struct packed {
    logic hold_only;  // beat only stores the first half of a pair
    logic split;
    logic sat;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

[hdl/tprc_ctrl.sv]
module tprc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tprc_pkg::status_t  status,
  output tprc_pkg::cmd_t     cmd
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMul   = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StEmit1 = 3'd4;
  localparam logic [2:0] StEmit2 = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != StIdle);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      StIdle: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!status.hold_only) state_nxt = StMul;
        end
      end
      StMul: begin
        cmd.mul   = 1'b1;
        state_nxt = StCheck;
      end
      StCheck: begin
        cmd.check = 1'b1;
        state_nxt = status.sat ? StEmit1 : StDiv;
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = StEmit1;
      end
      StEmit1: begin
        if (status.out_free) begin
          cmd.emit_first = 1'b1;
          state_nxt      = status.split ? StEmit2 : StIdle;
        end
      end
      StEmit2: begin
        if (status.out_free) begin
          cmd.emit_second = 1'b1;
          state_nxt       = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/tprc_dp.sv]
module tprc_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [tprc_pkg::RateW-1:0]   cfg_wdata,
  input  logic [tprc_pkg::LenW-1:0]    in_pulse_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tprc_pkg::LenW-1:0]    out_converted_length,
  output logic                         out_last_of_run,
  input  tprc_pkg::cmd_t               cmd,
  output tprc_pkg::status_t            status
);

  logic [tprc_pkg::RateW-1:0] in_rate_r;
  logic [tprc_pkg::RateW-1:0] out_rate_r;
  logic [tprc_pkg::ModeW-1:0] mode_r;

  logic [tprc_pkg::LenW-1:0]  held_r;
  logic                       pend_r;
  logic [tprc_pkg::SumW-1:0]  sum_r;
  logic                       split_r;
  logic [tprc_pkg::ProdW-1:0] prod_r;
  logic [tprc_pkg::LenW-1:0]  rem_r;
  logic [tprc_pkg::LenW-1:0]  quo_r;
  logic [tprc_pkg::CntW-1:0]  cnt_r;

  logic                       out_valid_r;
  logic [tprc_pkg::LenW-1:0]  out_len_r;
  logic                       out_last_r;

  logic [tprc_pkg::ProdW-1:0] mul_lo;
  logic [tprc_pkg::ProdW-1:0] mul_hi;
  logic [tprc_pkg::LenW:0]    trial;
  logic [tprc_pkg::LenW:0]    divisor;
  logic                       fits;
  logic [tprc_pkg::LenW-1:0]  half_q;

  // bit 32 of the sum adds out_rate shifted up by 32
  assign mul_lo = tprc_pkg::ProdW'(sum_r[tprc_pkg::LenW-1:0])
                * tprc_pkg::ProdW'(out_rate_r);
  assign mul_hi = sum_r[tprc_pkg::LenW]
                ? {1'b0, out_rate_r, {tprc_pkg::LenW{1'b0}}} : '0;

  assign divisor = {2'b00, in_rate_r};
  assign trial   = {rem_r, prod_r[tprc_pkg::ProdW-1]};
  assign fits    = (trial >= divisor);
  assign half_q  = quo_r >> 1;

  assign status.hold_only = (mode_r == tprc_pkg::ModeHalfToFull) && !pend_r;
  assign status.split     = split_r;
  // quotient overflows 32 bits exactly when the top half reaches the divisor
  assign status.sat       = ({1'b0, prod_r[tprc_pkg::ProdW-1:tprc_pkg::LenW]}
                             >= divisor);
  assign status.div_last  = (cnt_r == tprc_pkg::CntW'(tprc_pkg::DivSteps - 1));
  assign status.out_free  = !out_valid_r || !out_stall;

  assign out_valid            = out_valid_r;
  assign out_converted_length = out_len_r;
  assign out_last_of_run      = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_rate_r  <= tprc_pkg::RateReset;
      out_rate_r <= tprc_pkg::RateReset;
      mode_r     <= tprc_pkg::ModeUnchanged;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tprc_pkg::RegInRate:   in_rate_r  <= cfg_wdata;
        tprc_pkg::RegOutRate:  out_rate_r <= cfg_wdata;
        tprc_pkg::RegWaveMode: mode_r     <= cfg_wdata[tprc_pkg::ModeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      pend_r <= 1'b0;
    end else if (cmd.accept && (mode_r == tprc_pkg::ModeHalfToFull)) begin
      if (!pend_r) held_r <= in_pulse_length;
      pend_r <= !pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (mode_r == tprc_pkg::ModeHalfToFull) begin
        sum_r <= tprc_pkg::SumW'(held_r) + tprc_pkg::SumW'(in_pulse_length);
      end else begin
        sum_r <= tprc_pkg::SumW'(in_pulse_length);
      end
      split_r <= (mode_r == tprc_pkg::ModeFullToHalf);
    end
    if (cmd.mul) begin
      prod_r <= mul_lo + mul_hi;
    end
    if (cmd.check) begin
      rem_r  <= prod_r[tprc_pkg::ProdW-1:tprc_pkg::LenW];
      prod_r <= {prod_r[tprc_pkg::LenW-1:0], {tprc_pkg::LenW{1'b0}}};
      cnt_r  <= '0;
      if (status.sat) quo_r <= '1;
    end
    if (cmd.div_step) begin
      rem_r  <= fits ? tprc_pkg::LenW'(trial - divisor) : trial[tprc_pkg::LenW-1:0];
      prod_r <= prod_r << 1;
      quo_r  <= {quo_r[tprc_pkg::LenW-2:0], fits};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_first || cmd.emit_second) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_first) begin
      out_len_r  <= split_r ? half_q : quo_r;
      out_last_r <= !split_r;
    end else if (cmd.emit_second) begin
      out_len_r  <= quo_r - half_q;
      out_last_r <= 1'b1;
    end
  end

endmodule

[hdl/tape_pulse_rate_converter.sv]
// Rescales tape pulse lengths from input-clock ticks to output-clock ticks as
// floor(length * out_rate / in_rate), saturating at 32 bits; the wave mode
// register can pair half waves into full waves or split each pulse into two
// halves. One pulse is processed at a time. A beat that only holds the first
// half of a pair ends with its accept; any other beat passes through the
// accept, a multiply, a range check, a one-bit-per-cycle restoring divider
// and the output load, and skips the divider when the quotient saturates.
// Split pulses have a further output load for the second result, and each
// output load waits for as long as a result is stalled. A waiting result
// sits in an output register while the next beat is taken.
// Write configuration only while the block is idle.
`include "assert_macros.svh"

module tape_pulse_rate_converter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [tprc_pkg::RateW-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tprc_pkg::LenW-1:0]   in_pulse_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tprc_pkg::LenW-1:0]   out_converted_length,
  output logic                        out_last_of_run
);

  tprc_pkg::cmd_t    cmd;
  tprc_pkg::status_t status;

  tprc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tprc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_pulse_length      (in_pulse_length),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_converted_length (out_converted_length),
    .out_last_of_run      (out_last_of_run),
    .cmd                  (cmd),
    .status               (status)
  );

  // never overwrite a result that is still waiting
  `ASSERT_IMP(a_no_overwrite, (cmd.emit_first || cmd.emit_second), status.out_free, "result overwritten")
  // the second half always follows its first half
  `ASSERT_NXT(a_second_follows, (out_valid && !out_stall && !out_last_of_run), out_valid, "second half missing")
  // no beat is taken while a pulse is in progress
  `ASSERT_IMP(a_busy_stall, (cmd.div_step || cmd.mul || cmd.check), in_stall, "beat taken while busy")

endmodule
